// File: sv/iss_pkg.sv
`default_nettype none
package iss_pkg;

  localparam int POSITION_BITS = 32;
  localparam int WINDOW_BYTES  = 8;
  localparam int FORMATS       = 4;

  localparam logic [31:0] MIN_GAP_RESET    = 32'd1000;
  localparam logic [6:0]  MAX_IMAGES_RESET = 7'd10;
  localparam logic [6:0]  FOUND_MAX        = 7'd127;

  // configuration register indexes
  localparam logic CFG_MIN_GAP    = 1'b0;
  localparam logic CFG_MAX_IMAGES = 1'b1;

  // record kinds
  localparam logic REC_IMAGE = 1'b0;
  localparam logic REC_END   = 1'b1;

  localparam logic [1:0] FMT_PNG = 2'd0;

  // signatures in priority order: png, jpeg, gif, bmp
  localparam logic [7:0] SIG_BYTES [FORMATS][WINDOW_BYTES] = '{
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] SIG_LEN [FORMATS] = '{4'd8, 4'd3, 4'd4, 4'd2};

  typedef logic [WINDOW_BYTES-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    S_SCAN,
    S_TAIL,
    S_END
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [1:0]  image_format;
    logic [31:0] byte_position;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] fmt;
  } match_t;

  // signature test at window index idx; index 0 is the oldest byte
  function automatic match_t sig_match(win_t win, logic [2:0] idx);
    match_t     res;
    logic       ok;
    logic [3:0] avail;
    int         sel;
    res.hit = 1'b0;
    res.fmt = FMT_PNG;
    avail   = 4'd8 - {1'b0, idx};
    for (int s = FORMATS - 1; s >= 0; s--) begin
      ok = (SIG_LEN[s] <= avail);
      for (int k = 0; k < WINDOW_BYTES; k++) begin
        sel = int'(idx) + k;
        if (k < int'(SIG_LEN[s]) && sel < WINDOW_BYTES) begin
          if (win[sel[2:0]] != SIG_BYTES[s][k]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        res.hit = 1'b1;
        res.fmt = 2'(s);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: sv/image_signature_scanner.sv
`default_nettype none
// channel  direction  handshake          word
// in_      input      in_valid/in_stall   iss_pkg::in_word_t (data_byte, last_byte)
// out_     output     out_valid/out_stall iss_pkg::out_word_t (kind, format, position, last)
// cfg_     input      cfg_we              cfg_index selects min_gap or max_images
//
// one byte per cycle while scanning and the fifo has room; the window test, gap add and limit check
// sit between the window registers and a two-word output fifo.
// after a byte marked last, a sequencer walks the tail one window index per cycle while the
// fifo has room, then the end record is written.
// in_stall is high through the tail walk and the end record, and while the fifo is full.
// reset is synchronous on rst_n; stream state and config return to defaults.
module image_signature_scanner #(
  parameter int POSITION_BITS = iss_pkg::POSITION_BITS
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic                     in_stall,
  input  wire iss_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire                logic out_stall,
  output iss_pkg::out_word_t       out_data,
  input  wire                logic cfg_we,
  input  wire                logic cfg_index,
  input  wire         logic [31:0] cfg_wdata
);

  localparam int PB   = POSITION_BITS;
  localparam int EXTW = (PB > 32) ? PB : 32;
  localparam int SUMW = EXTW + 1;
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};

  iss_pkg::state_t state_r, state_nxt;

  logic [31:0]     gap_r;
  logic [6:0]      max_r;
  iss_pkg::win_t   win_r;
  logic [3:0]      fill_r;
  logic [PB-1:0]   cnt_r;
  logic [PB-1:0]   newest_r;
  logic [PB-1:0]   nsp_r;
  logic [6:0]      found_r;
  logic [2:0]      idx_r;

  iss_pkg::out_word_t fifo_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         fcnt_r, fcnt_nxt;

  logic               room, pop, in_acc;
  iss_pkg::win_t      win_shift;
  logic [3:0]         fill_inc;
  logic [3:0]         tail_start;

  logic               test_en, end_push, push, take;
  iss_pkg::win_t      test_win;
  logic [2:0]         test_idx;
  logic [PB-1:0]      test_newest;
  logic [PB-1:0]      test_pos;
  iss_pkg::match_t    m;
  logic [31:0]        gap_eff;
  logic [SUMW-1:0]    gap_sum;
  logic [PB-1:0]      nsp_new;
  logic [EXTW-1:0]    pos_ext, cnt_ext;
  iss_pkg::out_word_t push_rec;

  assign room      = (fcnt_r != 2'd2);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (state_r != iss_pkg::S_SCAN) || !room;
  assign in_acc    = in_valid && !in_stall;
  assign win_shift = {in_data.data_byte, win_r[iss_pkg::WINDOW_BYTES-1:1]};
  assign fill_inc  = (fill_r == 4'd8) ? 4'd8 : fill_r + 4'd1;
  assign tail_start = (fill_inc == 4'd8) ? 4'd1 : 4'd8 - fill_inc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iss_pkg::S_SCAN: begin
        if (in_acc && in_data.last_byte) state_nxt = iss_pkg::S_TAIL;
      end
      iss_pkg::S_TAIL: begin
        if (room && idx_r == 3'd7) state_nxt = iss_pkg::S_END;
      end
      iss_pkg::S_END: begin
        if (room) state_nxt = iss_pkg::S_SCAN;
      end
      default: state_nxt = iss_pkg::S_SCAN;
    endcase
  end

  always_comb begin
    test_en     = 1'b0;
    end_push    = 1'b0;
    test_win    = win_shift;
    test_idx    = 3'd0;
    test_newest = cnt_r;
    case (state_r)
      iss_pkg::S_SCAN: begin
        // oldest window byte is tested once the window holds eight bytes
        test_en = in_acc && (fill_r >= 4'd7);
      end
      iss_pkg::S_TAIL: begin
        test_en     = room;
        test_win    = win_r;
        test_idx    = idx_r;
        test_newest = newest_r;
      end
      iss_pkg::S_END: begin
        end_push = room;
      end
      default: begin
        test_en = 1'b0;
      end
    endcase
  end

  assign m        = iss_pkg::sig_match(test_win, test_idx);
  assign test_pos = test_newest - PB'(3'd7 - test_idx);
  assign take     = test_en && m.hit && (test_pos >= nsp_r) && (found_r < max_r);
  assign push     = take || end_push;
  assign gap_eff  = (gap_r == 32'd0) ? 32'd1 : gap_r;
  assign gap_sum  = SUMW'(test_pos) + SUMW'(gap_eff);
  assign nsp_new  = (gap_sum > SUMW'(PMAX)) ? PMAX : PB'(gap_sum);
  assign pos_ext  = EXTW'(test_pos);
  assign cnt_ext  = EXTW'(cnt_r);

  always_comb begin
    if (end_push) begin
      push_rec.record_kind   = iss_pkg::REC_END;
      push_rec.image_format  = iss_pkg::FMT_PNG;
      push_rec.byte_position = cnt_ext[31:0];
      push_rec.last_result   = 1'b1;
    end else begin
      push_rec.record_kind   = iss_pkg::REC_IMAGE;
      push_rec.image_format  = m.fmt;
      push_rec.byte_position = pos_ext[31:0];
      // a plain byte ends its results here; a last byte still has the end record
      push_rec.last_result   = (state_r == iss_pkg::S_SCAN) && !in_data.last_byte;
    end
  end

  assign fcnt_nxt  = fcnt_r + {1'b0, push} - {1'b0, pop};
  assign out_valid = (fcnt_r != 2'd0);
  assign out_data  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iss_pkg::S_SCAN;
      gap_r   <= iss_pkg::MIN_GAP_RESET;
      max_r   <= iss_pkg::MAX_IMAGES_RESET;
      fill_r  <= 4'd0;
      cnt_r   <= '0;
      nsp_r   <= '0;
      found_r <= 7'd0;
      idx_r   <= 3'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      fcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      fcnt_r  <= fcnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;

      if (cfg_we) begin
        case (cfg_index)
          iss_pkg::CFG_MIN_GAP:    gap_r <= cfg_wdata;
          iss_pkg::CFG_MAX_IMAGES: max_r <= cfg_wdata[6:0];
          default:                 gap_r <= gap_r;
        endcase
      end

      if (in_acc) begin
        fill_r <= fill_inc;
        if (cnt_r != PMAX) cnt_r <= cnt_r + PB'(1);
        if (in_data.last_byte) idx_r <= tail_start[2:0];
      end else if (state_r == iss_pkg::S_TAIL && room) begin
        idx_r <= idx_r + 3'd1;
      end

      if (take) begin
        nsp_r <= nsp_new;
        if (found_r != iss_pkg::FOUND_MAX) found_r <= found_r + 7'd1;
      end

      if (end_push) begin
        fill_r  <= 4'd0;
        cnt_r   <= '0;
        nsp_r   <= '0;
        found_r <= 7'd0;
      end
    end
  end

  // window and fifo words carry no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r    <= win_shift;
      newest_r <= cnt_r;
    end
    if (push) fifo_r[wp_r] <= push_rec;
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r != 2'd3)
    else $error("output fifo overfilled");

  a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != iss_pkg::S_SCAN) |-> in_stall)
    else $error("input taken during tail walk");

  a_last_starts_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) |=> (state_r == iss_pkg::S_TAIL))
    else $error("last word did not start tail walk");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_push |=> (fill_r == 4'd0 && found_r == 7'd0 && cnt_r == '0))
    else $error("stream state not cleared after end record");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_kind == iss_pkg::REC_END) |-> out_data.last_result)
    else $error("end record without last flag");

endmodule
`default_nettype wire

// File: sim/sig_scan_checker.sv
`timescale 1ns / 100ps
module sig_scan_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  iss_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  iss_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef enum logic [1:0] {
    IMG_PNG,
    IMG_JPEG,
    IMG_GIF,
    IMG_BMP
  } img_fmt_t;

  // stream state of the scanner as predicted here
  logic [7:0]  byte_win [8];
  logic [3:0]  win_fill;
  logic [31:0] byte_count;
  logic [31:0] next_pos;
  logic [6:0]  found;
  logic [31:0] gap_reg;
  logic [6:0]  limit_reg;

  iss_pkg::out_word_t step_records[$];
  iss_pkg::out_word_t expected_records[$];

  function automatic logic [63:0] sig_pattern(img_fmt_t f);
    case (f)
      IMG_PNG:  return 64'h89504E47_0D0A1A0A;
      IMG_JPEG: return 64'hFFD8FF00_00000000;
      IMG_GIF:  return 64'h47494638_00000000;
      default:  return 64'h424D0000_00000000;
    endcase
  endfunction

  function automatic int sig_length(img_fmt_t f);
    case (f)
      IMG_PNG:  return 8;
      IMG_JPEG: return 3;
      IMG_GIF:  return 4;
      default:  return 2;
    endcase
  endfunction

  // first format in priority order that fits and matches at window index idx
  function automatic int find_signature(int idx);
    img_fmt_t    f;
    logic [63:0] pat;
    bit          ok;
    for (int s = 0; s < 4; s++) begin
      f   = img_fmt_t'(s);
      pat = sig_pattern(f);
      ok  = (sig_length(f) <= 8 - idx);
      for (int k = 0; ok && k < sig_length(f); k++) begin
        if (byte_win[idx + k] != pat[63 - 8 * k -: 8]) ok = 1'b0;
      end
      if (ok) return s;
    end
    return -1;
  endfunction

  task automatic clear_stream();
    for (int i = 0; i < 8; i++) byte_win[i] = 8'h00;
    win_fill   = '0;
    byte_count = '0;
    next_pos   = '0;
    found      = '0;
  endtask

  task automatic test_start(int idx, logic [31:0] newest);
    logic [31:0]        pos;
    logic [31:0]        gap;
    logic [32:0]        nxt;
    int                 f;
    iss_pkg::out_word_t rec;
    pos = newest - 32'(7 - idx);
    if (pos < next_pos || found >= limit_reg) return;
    f = find_signature(idx);
    if (f < 0) return;
    rec.record_kind   = iss_pkg::REC_IMAGE;
    rec.image_format  = 2'(f);
    rec.byte_position = pos;
    rec.last_result   = 1'b0;
    step_records = {step_records, rec};
    if (found != 7'd127) found++;
    gap = (gap_reg == '0) ? 32'd1 : gap_reg;
    nxt = {1'b0, pos} + {1'b0, gap};
    next_pos = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
  endtask

  task automatic scan_byte(iss_pkg::in_word_t w);
    logic [31:0]        newest;
    iss_pkg::out_word_t rec;
    newest = byte_count;
    for (int i = 0; i < 7; i++) byte_win[i] = byte_win[i + 1];
    byte_win[7] = w.data_byte;
    if (win_fill < 4'd8) win_fill++;
    if (byte_count != 32'hFFFF_FFFF) byte_count++;
    if (win_fill == 4'd8) test_start(0, newest);
    if (w.last_byte) begin
      // flush the positions whose 8 bytes never arrived
      for (int i = 8 - int'(win_fill); i < 8; i++) begin
        if (i != 0) test_start(i, newest);
      end
      rec.record_kind   = iss_pkg::REC_END;
      rec.image_format  = IMG_PNG;
      rec.byte_position = byte_count;
      rec.last_result   = 1'b0;
      step_records = {step_records, rec};
      clear_stream();
    end
    for (int k = 0; k < step_records.size(); k++) begin
      rec = step_records[k];
      rec.last_result = (k == step_records.size() - 1);
      expected_records = {expected_records, rec};
    end
    step_records.delete();
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_record(iss_pkg::out_word_t got);
    iss_pkg::out_word_t want;
    if (expected_records.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected: kind %0d fmt %0d pos %0d",
                                got.record_kind, got.image_format, got.byte_position));
      return;
    end
    want = expected_records.pop_front();
    if (got.record_kind != want.record_kind)
      report_mismatch($sformatf("record_kind %0d, want %0d", got.record_kind,
                                want.record_kind));
    if (got.image_format != want.image_format)
      report_mismatch($sformatf("image_format %0d, want %0d", got.image_format,
                                want.image_format));
    if (got.byte_position != want.byte_position)
      report_mismatch($sformatf("byte_position %0d, want %0d", got.byte_position,
                                want.byte_position));
    if (got.last_result != want.last_result)
      report_mismatch($sformatf("last_result %0d, want %0d", got.last_result,
                                want.last_result));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      gap_reg   = 32'd1000;
      limit_reg = 7'd10;
      fail_count = 0;
      expected_records.delete();
    end else begin
      if (in_valid && !in_stall) scan_byte(in_data);
      if (out_valid && !out_stall) compare_record(out_data);
      // a write counts from the next word on
      if (cfg_we) begin
        case (cfg_index)
          iss_pkg::CFG_MIN_GAP:    gap_reg   = cfg_wdata;
          iss_pkg::CFG_MAX_IMAGES: limit_reg = cfg_wdata[6:0];
          default:                 gap_reg   = gap_reg;
        endcase
      end
    end
    pending <= expected_records.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_WORDS   = 36;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  iss_pkg::in_word_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = iss_pkg::CFG_MIN_GAP;
  logic [31:0]        cfg_wdata = '0;
  logic               in_stall;
  logic               out_valid;
  iss_pkg::out_word_t out_data;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   words_sent  = 0;
  int   stall_left  = 0;
  logic idle_on     = 1'b1;

  logic [7:0] stream_bytes[$];

  always #5 clk = ~clk;

  image_signature_scanner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sig_scan_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(logic [7:0] b, logic lst);
    int g;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.data_byte <= b;
    in_data.last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold off until every expected word is out and the scanner has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] gap, logic [6:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= iss_pkg::CFG_MIN_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= iss_pkg::CFG_MAX_IMAGES;
    cfg_wdata <= {25'($urandom), limit};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // half real signatures and near misses, a quarter lone signature bytes, the rest plain noise
  task automatic build_stream(int len);
    int f;
    int r;
    int cut;
    stream_bytes.delete();
    while (stream_bytes.size() < len) begin
      r = $urandom_range(0, 99);
      f = $urandom_range(0, iss_pkg::FORMATS - 1);
      if (r < 50) begin
        cut = (r < 35) ? int'(iss_pkg::SIG_LEN[f]) : $urandom_range(1, iss_pkg::SIG_LEN[f]);
        for (int k = 0; k < cut; k++)
          stream_bytes = {stream_bytes, iss_pkg::SIG_BYTES[f][k]};
        if (r >= 35 && $urandom_range(0, 1) == 1)
          stream_bytes[stream_bytes.size() - 1] = 8'($urandom_range(0, 255));
      end else if (r < 75) begin
        stream_bytes = {stream_bytes,
                        iss_pkg::SIG_BYTES[f][$urandom_range(0, iss_pkg::SIG_LEN[f] - 1)]};
      end else begin
        stream_bytes = {stream_bytes, 8'($urandom_range(0, 255))};
      end
    end
  endtask

  task automatic send_stream(bit split);
    int n;
    n = stream_bytes.size();
    for (int k = 0; k < n; k++) begin
      // new gap while a stream is half way through
      if (split && n >= 4 && k == n / 2) begin
        settle();
        set_config(32'($urandom_range(1, 6)), 7'd2);
      end
      send_word(stream_bytes[k], k == n - 1);
    end
  endtask

  initial begin
    int len;
    int words_goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: one png
    stream_bytes = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    send_stream(1'b0);
    settle();
    set_config(32'd1, 7'd64);
    // jpeg, gif, then bmp found only in the tail
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'h47, 8'h49, 8'h46, 8'h38, 8'h42, 8'h4D, 8'h00};
    send_stream(1'b0);
    stream_bytes = '{8'h00};
    send_stream(1'b0);
    stream_bytes = '{8'h42};
    send_stream(1'b0);
    stream_bytes = '{8'h42, 8'h4D};
    send_stream(1'b0);
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF};
    send_stream(1'b0);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: set_config(32'd1, 7'd64);
        1: set_config(32'd0, 7'd127);
        2: set_config(32'hFFFF_FFFF, 7'd64);
        3: set_config(32'd2, 7'd1);
        4: set_config(32'd1, 7'd0);
        5: set_config(32'($urandom_range(1, 12)), 7'd3);
        6: set_config(32'd1000, 7'd10);
        default: begin
          set_config(32'd1, 7'd100);
          idle_on <= 1'b0;
        end
      endcase
      if (p == 3) begin
        build_stream(12);
        send_stream(1'b1);
      end
      words_goal = words_sent + PHASE_WORDS;
      while (words_sent < words_goal) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        build_stream(len);
        send_stream(1'b0);
      end
    end

    settle();
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
